FILE: src/rcw_pkg.sv
package rcw_pkg;

    // fixed field widths
    localparam int SIZE_W = 13;
    localparam int RING_W = 8;
    localparam int AMP_W  = 9;
    localparam int COS_W  = 16;
    localparam int ATAN_N = 24;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd500;
    localparam logic [RING_W-1:0] RING_RESET = 8'd6;
    localparam logic [AMP_W-1:0]  AMP_RESET  = 9'd128;
    localparam logic [AMP_W-1:0]  AMP_MAX    = 9'd256;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 13'd2;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_IMAGE_SIZE = 2'd0,
        REG_RING_COUNT = 2'd1,
        REG_AMPLITUDE  = 2'd2
    } cfg_reg_t;

    // CORDIC gain compensation, Q.30
    localparam logic signed [32:0] CORDIC_K = 33'sd652032874;
    localparam logic signed [COS_W-1:0] COS_ONE = 16'sd16384;

    // arctangent of 2^-i in Q0.32 turns
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

FILE: src/ripple_coordinate_warp.sv
// Radial ripple warp of a pixel coordinate. Each request carries an unsigned
// Q12.8 pair; the result is x plus amplitude*cos(2*pi*r*2*rings/size), with
// r the distance from the image centre, rounded to signed Q13.8, and y
// passed through. The block takes one request per clock while the result
// side is not stalled and runs a fixed pipeline: magnitude, squares, sum,
// a bit-per-stage square root (AW+1 stages), the ring scaling, a
// bit-per-stage divider by the image size (AW+10+32-F stages), the CORDIC
// cosine (min(CORDIC_STAGES,24)+2 stages), the amplitude product and the
// output register. A stall on the result side freezes the whole pipeline;
// nothing is lost. Configuration writes are always ready and must only be
// made while no request is in flight.
module ripple_coordinate_warp import rcw_pkg::*; #(
    parameter int COORD_INT_BITS  = 12,
    parameter int COORD_FRAC_BITS = 8,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] s_x_coord,
    input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] s_y_coord,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [COORD_INT_BITS+COORD_FRAC_BITS+1:0] m_x_warped,
    output logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] m_y_warped,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_addr,
    input  logic [SIZE_W-1:0]      cfg_wdata
);

    localparam int F   = COORD_FRAC_BITS;
    localparam int W   = COORD_INT_BITS + COORD_FRAC_BITS;
    localparam int CW  = SIZE_W + F - 1;              // centre width
    localparam int DW  = (W > CW) ? W : CW;           // |dx| width
    localparam int AW  = (DW > 31) ? 31 : DW;         // saturated |dx| width
    localparam int SQW = 2 * AW + 1;                  // dx^2 + dy^2
    localparam int RW  = AW + 1;                      // root width
    localparam int NW  = RW + RING_W + 1;             // r * 2 * rings
    localparam int QSH = 32 - F;                      // turn scaling
    localparam int NI  = (CORDIC_STAGES > ATAN_N) ? ATAN_N : CORDIC_STAGES;
    localparam int SW  = 2 * W;                       // x and y riding along
    localparam int PRW = AMP_W + 1 + COS_W;           // amplitude product
    localparam int XSW = (W + 2 > PRW) ? W + 2 : PRW;
    localparam logic signed [PRW-1:0] RND = PRW'(1) <<< (21 - F);

    // ---------------- configuration registers ----------------
    logic [SIZE_W-1:0] image_size_reg;
    logic [RING_W-1:0] ring_count_reg;
    logic [AMP_W-1:0]  amplitude_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_size_reg <= SIZE_RESET;
            ring_count_reg <= RING_RESET;
            amplitude_reg  <= AMP_RESET;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_IMAGE_SIZE: image_size_reg <= cfg_wdata;
                REG_RING_COUNT: ring_count_reg <= cfg_wdata[RING_W-1:0];
                REG_AMPLITUDE:  amplitude_reg  <= cfg_wdata[AMP_W-1:0];
                default: ;  // unknown index: dropped
            endcase
        end
    end

    // small sizes behave as 2, amplitude saturates at one pixel
    logic [SIZE_W-1:0] size_eff;
    logic [AMP_W-1:0]  amp_eff;
    assign size_eff = (image_size_reg < SIZE_MIN) ? SIZE_MIN : image_size_reg;
    assign amp_eff  = (amplitude_reg > AMP_MAX) ? AMP_MAX : amplitude_reg;

    // ---------------- global pipeline advance ----------------
    // Every stage moves together; a held result freezes the lot.
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ---------------- stage 1: distance from the centre ----------------
    logic [CW-1:0] centre;
    assign centre = {size_eff, {(F - 1){1'b0}}};

    function automatic logic [AW-1:0] abs_sat(input logic [W-1:0] c,
                                              input logic [CW-1:0] m);
        logic signed [DW:0] d;
        logic [DW-1:0]      mag;
        d   = $signed({1'b0, DW'(c)}) - $signed({1'b0, DW'(m)});
        mag = d[DW] ? DW'(-d) : d[DW-1:0];
        if (mag > DW'({AW{1'b1}})) begin
            return {AW{1'b1}};
        end
        return mag[AW-1:0];
    endfunction

    logic          v1_reg;
    logic [W-1:0]  x1_reg, y1_reg;
    logic [AW-1:0] ax1_reg, ay1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
        if (adv) begin
            x1_reg  <= s_x_coord;
            y1_reg  <= s_y_coord;
            ax1_reg <= abs_sat(s_x_coord, centre);
            ay1_reg <= abs_sat(s_y_coord, centre);
        end
    end

    // ---------------- stage 2: squares ----------------
    logic            v2_reg;
    logic [SW-1:0]   sb2_reg;
    logic [2*AW-1:0] sqx2_reg, sqy2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            sb2_reg  <= {x1_reg, y1_reg};
            sqx2_reg <= (2*AW)'(ax1_reg) * (2*AW)'(ax1_reg);
            sqy2_reg <= (2*AW)'(ay1_reg) * (2*AW)'(ay1_reg);
        end
    end

    // ---------------- stage 3: sum of squares ----------------
    logic           v3_reg;
    logic [SW-1:0]  sb3_reg;
    logic [SQW-1:0] sum3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
        if (adv) begin
            sb3_reg  <= sb2_reg;
            sum3_reg <= SQW'(sqx2_reg) + SQW'(sqy2_reg);
        end
    end

    // ---------------- radius: pipelined integer square root ----------------
    logic          sq_valid;
    logic [RW-1:0] sq_root;
    logic [SW-1:0] sq_sb;

    rcw_isqrt #(.IW(SQW), .RW(RW), .SW(SW)) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (v3_reg),
        .in_val   (sum3_reg),
        .in_sb    (sb3_reg),
        .out_valid(sq_valid),
        .out_root (sq_root),
        .out_sb   (sq_sb)
    );

    // ---------------- stage 4: scale by twice the ring count ----------------
    logic          v4_reg;
    logic [SW-1:0] sb4_reg;
    logic [NW-1:0] num4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= sq_valid;
        end
        if (adv) begin
            sb4_reg  <= sq_sb;
            num4_reg <= NW'(sq_root) * NW'({ring_count_reg, 1'b0});
        end
    end

    // ---------------- phase in turns: pipelined divide by size ----------------
    logic          dv_valid;
    logic [31:0]   dv_phase;
    logic [SW-1:0] dv_sb;

    rcw_div #(.NW(NW), .QSH(QSH), .SW(SW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (v4_reg),
        .in_num   (num4_reg),
        .divisor  (size_eff),
        .in_sb    (sb4_reg),
        .out_valid(dv_valid),
        .out_quot (dv_phase),
        .out_sb   (dv_sb)
    );

    // ---------------- cosine ----------------
    logic                    cs_valid;
    logic signed [COS_W-1:0] cs_cos;
    logic [SW-1:0]           cs_sb;

    rcw_cordic #(.NI(NI), .SW(SW)) u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (dv_valid),
        .in_phase (dv_phase),
        .in_sb    (dv_sb),
        .out_valid(cs_valid),
        .out_cos  (cs_cos),
        .out_sb   (cs_sb)
    );

    // ---------------- stage 5: amplitude product, Q.22 ----------------
    logic                  v5_reg;
    logic [SW-1:0]         sb5_reg;
    logic signed [PRW-1:0] p5_reg;
    logic signed [PRW-1:0] p_next;

    assign p_next = $signed({1'b0, amp_eff}) * cs_cos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= cs_valid;
        end
        if (adv) begin
            sb5_reg <= cs_sb;
            p5_reg  <= p_next;
        end
    end

    // ---------------- output register ----------------
    // displacement rounded half up to Q.F, added to x, wrapped to width
    logic signed [PRW-1:0] disp;
    logic signed [XSW-1:0] xsum;
    logic [W-1:0]          x5, y5;

    assign {x5, y5} = sb5_reg;
    assign disp     = (p5_reg + RND) >>> (22 - F);
    assign xsum     = XSW'($signed({1'b0, x5})) + XSW'(disp);

    logic                  m_valid_reg;
    logic signed [W+1:0]   m_x_warped_reg;
    logic [W-1:0]          m_y_warped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v5_reg;
        end
        if (adv) begin
            m_x_warped_reg <= xsum[W+1:0];
            m_y_warped_reg <= y5;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_x_warped = m_x_warped_reg;
    assign m_y_warped = m_y_warped_reg;

    a_no_result_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result shown straight after reset");

endmodule

FILE: src/rcw_isqrt.sv
module rcw_isqrt import rcw_pkg::*; #(
    parameter int IW = 41,
    parameter int RW = 21,
    parameter int SW = 40
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [IW-1:0] in_val,
    input  logic [SW-1:0] in_sb,
    output logic          out_valid,
    output logic [RW-1:0] out_root,
    output logic [SW-1:0] out_sb
);

    localparam int PW  = 2 * RW;
    localparam int RMW = RW + 3;

    logic [RMW-1:0] rem_reg  [RW];
    logic [RW-1:0]  root_reg [RW];
    logic [PW-1:0]  val_reg  [RW];
    logic [SW-1:0]  sb_reg   [RW];
    logic           vld_reg  [RW];

    // one root bit per stage, two radicand bits consumed
    genvar i;
    for (i = 0; i < RW; i++) begin : g_stage
        logic [RMW-1:0] rem_in, rem_sh, trial;
        logic [RW-1:0]  root_in;
        logic [PW-1:0]  val_in;
        logic [SW-1:0]  sb_in;
        logic           v_in, ge;

        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = PW'(in_val);
            assign sb_in   = in_sb;
            assign v_in    = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign val_in  = val_reg[i-1];
            assign sb_in   = sb_reg[i-1];
            assign v_in    = vld_reg[i-1];
        end

        assign rem_sh = {rem_in[RMW-3:0], val_in[PW-1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= v_in;
            end
            if (en) begin
                rem_reg[i]  <= ge ? rem_sh - trial : rem_sh;
                root_reg[i] <= {root_in[RW-2:0], ge};
                val_reg[i]  <= val_in << 2;
                sb_reg[i]   <= sb_in;
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_sb    = sb_reg[RW-1];

endmodule

FILE: src/rcw_div.sv
module rcw_div import rcw_pkg::*; #(
    parameter int NW  = 30,
    parameter int QSH = 24,
    parameter int SW  = 40
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NW-1:0]     in_num,
    input  logic [SIZE_W-1:0] divisor,
    input  logic [SW-1:0]     in_sb,
    output logic              out_valid,
    output logic [31:0]       out_quot,
    output logic [SW-1:0]     out_sb
);

    // dividend is in_num followed by QSH zero bits; only low 32 quotient bits kept
    localparam int ND = NW + QSH;

    logic [SIZE_W-1:0] rem_reg  [ND];
    logic [31:0]       quot_reg [ND];
    logic [NW-1:0]     num_reg  [ND];
    logic [SW-1:0]     sb_reg   [ND];
    logic              vld_reg  [ND];

    genvar i;
    for (i = 0; i < ND; i++) begin : g_stage
        logic [SIZE_W-1:0] rem_in;
        logic [31:0]       quot_in;
        logic [NW-1:0]     num_in;
        logic [SW-1:0]     sb_in;
        logic              v_in, ge;
        logic [SIZE_W:0]   trial;

        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign quot_in = '0;
            assign num_in  = in_num;
            assign sb_in   = in_sb;
            assign v_in    = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign quot_in = quot_reg[i-1];
            assign num_in  = num_reg[i-1];
            assign sb_in   = sb_reg[i-1];
            assign v_in    = vld_reg[i-1];
        end

        assign trial = {rem_in, num_in[NW-1]};
        assign ge    = trial >= {1'b0, divisor};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= v_in;
            end
            if (en) begin
                rem_reg[i]  <= ge ? SIZE_W'(trial - {1'b0, divisor}) : SIZE_W'(trial);
                quot_reg[i] <= {quot_in[30:0], ge};
                num_reg[i]  <= num_in << 1;
                sb_reg[i]   <= sb_in;
            end
        end
    end

    assign out_valid = vld_reg[ND-1];
    assign out_quot  = quot_reg[ND-1];
    assign out_sb    = sb_reg[ND-1];

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ND-1] |-> (rem_reg[ND-1] < divisor))
        else $error("divider remainder not below divisor");

endmodule

FILE: src/rcw_cordic.sv
module rcw_cordic import rcw_pkg::*; #(
    parameter int NI = 16,
    parameter int SW = 40
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [31:0]             in_phase,
    input  logic [SW-1:0]           in_sb,
    output logic                    out_valid,
    output logic signed [COS_W-1:0] out_cos,
    output logic [SW-1:0]           out_sb
);

    localparam int XYW = 33;

    logic signed [XYW-1:0] cx_reg [NI+1];
    logic signed [XYW-1:0] cy_reg [NI+1];
    logic signed [32:0]    z_reg  [NI+1];
    logic                  flip_reg [NI+1];
    logic [SW-1:0]         sb_reg [NI+1];
    logic                  vld_reg [NI+1];

    logic                    cos_vld_reg;
    logic signed [COS_W-1:0] cos_reg;
    logic [SW-1:0]           cos_sb_reg;

    // fold into [-1/4, 1/4) turn
    logic [31:0] ph_sum, ph_fold;
    logic        flip_in;
    assign ph_sum  = in_phase + 32'h4000_0000;
    assign flip_in = ph_sum[31];
    assign ph_fold = flip_in ? {~in_phase[31], in_phase[30:0]} : in_phase;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
        if (en) begin
            cx_reg[0]   <= CORDIC_K;
            cy_reg[0]   <= '0;
            z_reg[0]    <= 33'($signed(ph_fold));
            flip_reg[0] <= flip_in;
            sb_reg[0]   <= in_sb;
        end
    end

    genvar i;
    for (i = 0; i < NI; i++) begin : g_iter
        logic signed [XYW-1:0] sx, sy;
        logic signed [32:0]    at;
        assign sx = cx_reg[i] >>> i;
        assign sy = cy_reg[i] >>> i;
        assign at = $signed({1'b0, atan_turn(5'(i))});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            if (en) begin
                if (!z_reg[i][32]) begin
                    cx_reg[i+1] <= cx_reg[i] - sy;
                    cy_reg[i+1] <= cy_reg[i] + sx;
                    z_reg[i+1]  <= z_reg[i] - at;
                end else begin
                    cx_reg[i+1] <= cx_reg[i] + sy;
                    cy_reg[i+1] <= cy_reg[i] - sx;
                    z_reg[i+1]  <= z_reg[i] + at;
                end
                flip_reg[i+1] <= flip_reg[i];
                sb_reg[i+1]   <= sb_reg[i];
            end
        end
    end

    // round to Q1.14, clamp, undo the fold
    logic signed [XYW-1:0]   c_full;
    logic signed [COS_W-1:0] c_clamp, cos_next;
    assign c_full = (cx_reg[NI] + 33'sd32768) >>> 16;

    always_comb begin
        if (c_full > XYW'(COS_ONE)) begin
            c_clamp = COS_ONE;
        end else if (c_full < -XYW'(COS_ONE)) begin
            c_clamp = -COS_ONE;
        end else begin
            c_clamp = COS_W'(c_full);
        end
        cos_next = flip_reg[NI] ? -c_clamp : c_clamp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_vld_reg <= 1'b0;
        end else if (en) begin
            cos_vld_reg <= vld_reg[NI];
        end
        if (en) begin
            cos_reg    <= cos_next;
            cos_sb_reg <= sb_reg[NI];
        end
    end

    assign out_valid = cos_vld_reg;
    assign out_cos   = cos_reg;
    assign out_sb    = cos_sb_reg;

    a_cos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cos_vld_reg |-> (cos_reg <= COS_ONE && cos_reg >= -COS_ONE))
        else $error("cosine outside unit range");

endmodule

FILE: test/ripple_coordinate_warp_tb.sv
`timescale 1ns / 1ps

// Checks the radial ripple warp end to end.
// A behavioural model computes the displaced x for every accepted request
// from its own copy of the three registers. Results are compared in order
// against the queue of predictions as they leave the block. Both sides idle
// at random. One phase holds the result side off long enough to back the
// pipeline up into the request side.
module ripple_coordinate_warp_tb;
    import rcw_pkg::*;

    localparam int CW     = 20;            // coordinate width, Q12.8
    localparam int XW     = CW + 2;        // warped x width, Q13.8
    localparam int FRAC   = 8;
    localparam int STAGES = 16;
    localparam int SETTLE = 130;           // longer than the pipeline latency
    localparam logic [CW-1:0] COORD_MAX = '1;
    // index with no register behind it; writes there must be ignored
    localparam logic [1:0] REG_NONE = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [CW-1:0]         s_x_coord;
    logic [CW-1:0]         s_y_coord;
    logic                  m_valid;
    logic                  m_ready;
    logic signed [XW-1:0]  m_x_warped;
    logic [CW-1:0]         m_y_warped;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_addr;
    logic [SIZE_W-1:0]     cfg_wdata;

    typedef struct packed {
        logic [XW-1:0] x_warped;
        logic [CW-1:0] y_warped;
    } warp_res_t;

    // predicted results, oldest first
    warp_res_t warp_pending[$];

    // register shadow
    logic [SIZE_W-1:0] img_size;
    logic [RING_W-1:0] rings;
    logic [AMP_W-1:0]  ampl;

    int unsigned errors;
    int unsigned n_requests;
    int unsigned n_results;
    int unsigned n_cfg_writes;
    bit          idle_on;       // random gaps on the request side
    bit          stall_on;      // random stalls on the result side
    bit          hold_req;      // ask receiver for one long hold-off

    ripple_coordinate_warp DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_x_coord  (s_x_coord),
        .s_y_coord  (s_y_coord),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_x_warped (m_x_warped),
        .m_y_warped (m_y_warped),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Model
    // ---------------------------------------------------------------

    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned acc;
        longint unsigned bitv;
        acc  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= acc + bitv) begin
                v   = v - (acc + bitv);
                acc = (acc >> 1) + bitv;
            end else begin
                acc = acc >> 1;
            end
            bitv = bitv >> 2;
        end
        return acc;
    endfunction

    // cosine of a Q0.32 turn phase as Q1.14, rotation mode CORDIC in Q.30
    function automatic longint ripple_cos(input logic [31:0] ph);
        logic   [31:0] p;
        logic   [31:0] folded;
        bit            flip;
        longint        cx;
        longint        cy;
        longint        z;
        longint        sx;
        longint        sy;
        longint        c;
        folded = ph + 32'h4000_0000;
        flip   = folded[31];
        p      = flip ? ph - 32'h8000_0000 : ph;
        z      = longint'($signed(p));
        cx     = longint'(CORDIC_K);
        cy     = 0;
        for (int i = 0; i < STAGES && i < ATAN_N; i++) begin
            sx = cx >>> i;
            sy = cy >>> i;
            if (z >= 0) begin
                cx = cx - sy;
                cy = cy + sx;
                z  = z - longint'(atan_turn(i[4:0]));
            end else begin
                cx = cx + sy;
                cy = cy - sx;
                z  = z + longint'(atan_turn(i[4:0]));
            end
        end
        c = (cx + 32768) >>> 16;
        if (c > 16384) c = 16384;
        if (c < -16384) c = -16384;
        return flip ? -c : c;
    endfunction

    function automatic warp_res_t warp_coord(input logic [CW-1:0] x, input logic [CW-1:0] y);
        longint unsigned n;
        longint unsigned amp;
        longint          centre;
        longint          dx;
        longint          dy;
        longint unsigned r;
        longint unsigned num;
        longint unsigned quo;
        longint unsigned rem;
        logic [31:0]     phase;
        longint          disp;
        longint          xw;
        warp_res_t       res;
        n      = (img_size < 2) ? 2 : img_size;
        amp    = (ampl > 256) ? 256 : ampl;
        centre = longint'(n << (FRAC - 1));
        dx     = longint'(x) - centre;
        dy     = longint'(y) - centre;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        r      = isqrt(longint'(dx * dx + dy * dy));
        num    = r * 2 * rings;
        quo    = num / n;
        rem    = num % n;
        phase  = 32'((quo << (32 - FRAC)) + ((rem << (32 - FRAC)) / n));
        disp   = (longint'(amp) * ripple_cos(phase) + (64'sd1 << (21 - FRAC))) >>> (22 - FRAC);
        xw     = longint'(x) + disp;
        res.x_warped = xw[XW-1:0];
        res.y_warped = y;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Shared helpers
    // ---------------------------------------------------------------

    // mostly back to back, now and then a long gap
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one request; entered and left at a falling edge
    task automatic send_coord(input logic [CW-1:0] x, input logic [CW-1:0] y);
        int unsigned gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_x_coord <= x;
        s_y_coord <= y;
        s_valid   <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        warp_pending.push_back(warp_coord(x, y));
        n_requests++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (warp_pending.size() != 0) @(negedge aclk);
        // let anything unexpected still inside come out
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [SIZE_W-1:0] data);
        cfg_addr  <= addr;
        cfg_wdata <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (addr)
            REG_IMAGE_SIZE: img_size = data;
            REG_RING_COUNT: rings    = data[RING_W-1:0];
            REG_AMPLITUDE:  ampl     = data[AMP_W-1:0];
            default: ;      // no register here
        endcase
        n_cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_ripple(input logic [SIZE_W-1:0] sz, input logic [SIZE_W-1:0] rc,
                              input logic [SIZE_W-1:0] am);
        write_reg(REG_IMAGE_SIZE, sz);
        write_reg(REG_RING_COUNT, rc);
        write_reg(REG_AMPLITUDE, am);
    endtask

    // coordinate mostly inside the image, sometimes anywhere
    function automatic logic [CW-1:0] pick_coord();
        longint unsigned span;
        span = longint'(img_size) << FRAC;
        if (span > COORD_MAX) span = COORD_MAX;
        if ($urandom_range(0, 9) < 8) return CW'($urandom_range(0, int'(span)));
        return CW'($urandom);
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic test_corner_points();
        logic [CW-1:0] mid;
        mid = CW'(longint'(img_size) << (FRAC - 1));
        send_coord('0, '0);
        send_coord(COORD_MAX, COORD_MAX);
        send_coord('0, COORD_MAX);
        send_coord(COORD_MAX, '0);
        send_coord(mid, mid);               // centre: zero radius, full swing
        send_coord(CW'(mid + 1), mid);
        send_coord(mid, '0);
        send_coord(20'h55555, 20'hAAAAA);
        send_coord(20'hAAAAA, 20'h55555);
        drain();
    endtask

    task automatic test_register_corners();
        // sizes below the minimum act as two; no rings means zero phase
        set_ripple(13'd0, 13'd0, 13'd256);
        send_coord('0, '0);
        send_coord(COORD_MAX, 20'h00100);
        drain();
        set_ripple(13'd1, 13'd255, 13'd511);    // amplitude above one saturates
        send_coord(20'h00080, 20'h00080);
        send_coord(20'h12345, 20'h0FEDC);
        drain();
        set_ripple(13'd8191, 13'd1, 13'd0);     // oversize image used as is
        send_coord(COORD_MAX, '0);
        send_coord(20'h80000, 20'h80000);
        drain();
        // data wider than the field is cut to it
        set_ripple(13'd4096, 13'h1FF, 13'h1FFF);
        send_coord(20'h00000, 20'hFFFFF);
        send_coord(20'h80000, 20'h7FF00);
        drain();
        write_reg(REG_NONE, 13'h1ABC);          // nothing there, nothing changes
        send_coord(20'h3C000, 20'h01000);
        drain();
    endtask

    task automatic test_config_sweep();
        logic [SIZE_W-1:0] sz;
        for (int set = 0; set < 12; set++) begin
            case (set)
                0:  set_ripple(13'd2, 13'd1, 13'd0);
                1:  set_ripple(13'd4096, 13'd255, 13'd256);
                2:  set_ripple(13'd3, 13'd17, 13'd1);
                3:  set_ripple(13'd4095, 13'd128, 13'd255);
                default: begin
                    sz = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom) :
                         SIZE_W'($urandom_range(2, 4096));
                    set_ripple(sz, SIZE_W'($urandom_range(0, 255)),
                               SIZE_W'($urandom_range(0, 300)));
                end
            endcase
            repeat (30) send_coord(pick_coord(), pick_coord());
            drain();
        end
    endtask

    // long bursts in good order, some stretches without any idling
    task automatic test_random_stream();
        set_ripple(SIZE_RESET, RING_RESET, AMP_RESET);
        for (int burst = 0; burst < 8; burst++) begin
            idle_on  = (burst % 3) != 2;
            stall_on = (burst % 4) != 3;
            repeat (90) send_coord(pick_coord(), pick_coord());
            drain();
            set_ripple(SIZE_W'($urandom_range(2, 4096)), SIZE_W'($urandom_range(1, 255)),
                       SIZE_W'($urandom_range(0, 256)));
        end
        idle_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    // result side holds off while requests keep coming
    task automatic test_backpressure();
        set_ripple(13'd640, 13'd9, 13'd200);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (200) send_coord(pick_coord(), pick_coord());
        idle_on  = 1'b1;
        drain();
    endtask

    // ---------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------

    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (500) @(negedge aclk);   // long enough to fill the pipe
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (stall_on && pick_gap() > 0) begin
                m_ready <= 1'b0;
                repeat (pick_gap() + 1) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        warp_res_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (warp_pending.size() == 0) begin
                $display("%0t: result with nothing pending: x %h y %h",
                         $time, m_x_warped, m_y_warped);
                errors++;
            end else begin
                want = warp_pending.pop_front();
                if (m_x_warped !== want.x_warped) begin
                    $display("%0t: x_warped expected %h actual %h",
                             $time, want.x_warped, m_x_warped);
                    errors++;
                end
                if (m_y_warped !== want.y_warped) begin
                    $display("%0t: y_warped expected %h actual %h",
                             $time, want.y_warped, m_y_warped);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_x_coord = '0;
        s_y_coord = '0;
        cfg_valid = 1'b0;
        cfg_addr  = REG_IMAGE_SIZE;
        cfg_wdata = '0;
        img_size  = SIZE_RESET;
        rings     = RING_RESET;
        ampl      = AMP_RESET;
        errors    = 0;
        idle_on   = 1'b1;
        stall_on  = 1'b1;
        hold_req  = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_corner_points();       // reset values still in force
        test_register_corners();
        test_config_sweep();
        test_random_stream();
        test_backpressure();

        if (warp_pending.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, warp_pending.size());
            errors++;
        end
        $display("Covered %0d requests, %0d results, %0d register writes,",
                 n_requests, n_results, n_cfg_writes);
        $display("including degenerate sizes, zero rings, saturated amplitude, long stall.");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
